// ===== sv/lbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lbs_pkg
// Types, constants and arithmetic helpers shared by the skinning block.
// ============================================================================
package lbs_pkg;

    localparam int VERTEX_DEPTH_DEF = 4096;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;
    localparam int WEIGHT_W = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

    typedef enum logic [2:0] {
        CMD_LOAD_SOURCE = 3'd0,
        CMD_SET_POSE    = 3'd1,
        CMD_START_FRAME = 3'd2,
        CMD_INFLUENCE   = 3'd3,
        CMD_READ        = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COPY_READ,
        ST_COPY_WRITE,
        ST_PROD,
        ST_INF_READ,
        ST_INF_DIFF,
        ST_INF_MUL,
        ST_INF_SUM,
        ST_INF_WEIGHT,
        ST_INF_WRITE,
        ST_RD_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [INDEX_W-1:0] vertex_index;
        logic [2:0]         pose_row;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic signed [31:0] position_part;
        logic [WEIGHT_W-1:0] influence_weight;
    } cmd_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } vertex_item_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -50'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat47(input logic signed [49:0] v);
        if (v > 50'sh3FFFFFFFFFFF)
            return 48'sh3FFFFFFFFFFF;
        else if (v < -50'sh400000000000)
            return 48'shC00000000000;
        return v[47:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/lbs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lbs_if
// Valid/ready channel carrying one payload per transfer.
// ============================================================================
interface lbs_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/linear_blend_skinning_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// linear_blend_skinning_top
// Linear blend skinning engine over a Q16.16 vertex store.
// ============================================================================
// Loads and pose rows are done at their transfer. An influence to a valid
// vertex keeps the command input closed until its write back is done: first
// the 3x3 pose matrix is built with 27 products on one shared 32x32
// multiplier, then a read of the vertex memories, 9 more products, 3 weight
// products and the write back follow. Once a pose row changes the matrix is
// rebuilt at the next influence; later influences reuse it and go straight
// to the vertex read. A read passes through a wait state and an output state
// before its result is shown, and no command is taken until that result has
// been transferred. Start frame copies the configured vertices one at a time.
module linear_blend_skinning_top
    import lbs_pkg::*;
#(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lbs_if.sink       cmd,
    lbs_if.source     result,
    lbs_if.sink       cfg
);
    localparam int AW = $clog2(VERTEX_DEPTH);

    logic signed [31:0] src_mem [VERTEX_DEPTH][3];
    logic signed [31:0] skn_mem [VERTEX_DEPTH][3];

    state_t state_reg, state_next;
    cmd_item_t item_reg;
    logic [COUNT_W-1:0] active_reg;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic signed [31:0] rot_reg [9];
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] brot_reg [9];
    logic signed [31:0] bpos_reg [3];
    logic signed [31:0] dm_reg [9];
    logic signed [49:0] acc_reg;
    logic dm_valid_reg;
    logic signed [31:0] src_rd_reg [3];
    logic signed [31:0] skn_rd_reg [3];
    logic signed [31:0] d_reg [3];
    logic signed [49:0] e_reg [3];
    logic signed [47:0] es_reg [3];
    logic signed [31:0] new_reg [3];
    logic signed [63:0] prod_reg;
    logic prod_en_reg;
    logic [4:0] step_reg, step_next;
    logic [1:0] si_reg, si_next;
    logic [1:0] sj_reg, sj_next;
    logic [1:0] sk_reg, sk_next;
    logic [1:0] pi_reg, pj_reg;
    logic [3:0] pm_reg;
    vertex_item_t out_reg;
    logic out_valid_reg;

    logic [COUNT_W-1:0] copy_n;
    logic idx_ok;
    logic load_ok;
    logic [AW-1:0] vaddr, caddr;
    logic [3:0] rot_idx, brot_idx, dm_idx;
    logic [1:0] prow;
    logic [3:0] pbase;
    logic signed [31:0] mul_a, mul_b;
    logic mul_en;
    logic [WEIGHT_W-1:0] wclamp;

    assign idx_ok = (32'(item_reg.vertex_index) < 32'(VERTEX_DEPTH));
    assign load_ok = (32'(cmd.data.vertex_index) < 32'(VERTEX_DEPTH));
    assign vaddr = AW'(item_reg.vertex_index);
    assign caddr = AW'(cnt_reg);
    assign copy_n = (32'(active_reg) > 32'(VERTEX_DEPTH)) ?
                    COUNT_W'(VERTEX_DEPTH) : active_reg;
    assign wclamp = (item_reg.influence_weight > WEIGHT_ONE) ?
                    WEIGHT_ONE : item_reg.influence_weight;
    assign cmd.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data = out_reg;

    // Row i, column k and inner term j of the matrix products are counted
    // separately.
    always_comb
    begin
        rot_idx = {2'b00, si_reg} * 4'd3 + {2'b00, sj_reg};
        brot_idx = {2'b00, sk_reg} * 4'd3 + {2'b00, sj_reg};
        dm_idx = {2'b00, si_reg} * 4'd3 + {2'b00, sk_reg};
    end

    always_comb
    begin
        if (cmd.data.pose_row < 3'd3)
            prow = cmd.data.pose_row[1:0];
        else
            prow = 2'(cmd.data.pose_row - 3'd3);
        pbase = {2'b00, prow} * 4'd3;
    end

    always_comb
    begin
        mul_en = 1'b0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_PROD:
            begin
                if (step_reg != 5'd27)
                begin
                    mul_en = 1'b1;
                    mul_a = rot_reg[rot_idx];
                    mul_b = brot_reg[brot_idx];
                end
            end
            ST_INF_MUL:
            begin
                if (step_reg != 5'd9)
                begin
                    mul_en = 1'b1;
                    mul_a = dm_reg[dm_idx];
                    mul_b = d_reg[sk_reg];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        si_next = si_reg;
        sj_next = sj_reg;
        sk_next = sk_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                cnt_next = '0;
                si_next = '0;
                sj_next = '0;
                sk_next = '0;
                if (cmd.valid && cmd.ready)
                begin
                    case (cmd.data.command)
                        CMD_START_FRAME: state_next = ST_COPY_READ;
                        CMD_INFLUENCE:   state_next = ST_PROD;
                        CMD_READ:        state_next = ST_RD_WAIT;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COPY_READ:
            begin
                if (cnt_reg >= copy_n)
                    state_next = ST_IDLE;
                else
                    state_next = ST_COPY_WRITE;
            end
            ST_COPY_WRITE:
            begin
                cnt_next = cnt_reg + 1'b1;
                state_next = ST_COPY_READ;
            end
            ST_PROD:
            begin
                if (!idx_ok)
                    state_next = ST_IDLE;
                else if (dm_valid_reg)
                    state_next = ST_INF_READ;
                else if (step_reg == 5'd27)
                begin
                    state_next = ST_INF_READ;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                    if (sj_reg == 2'd2)
                    begin
                        sj_next = '0;
                        if (sk_reg == 2'd2)
                        begin
                            sk_next = '0;
                            si_next = si_reg + 1'b1;
                        end
                        else
                            sk_next = sk_reg + 1'b1;
                    end
                    else
                        sj_next = sj_reg + 1'b1;
                end
            end
            ST_INF_READ:
            begin
                state_next = ST_INF_DIFF;
            end
            ST_INF_DIFF:
            begin
                step_next = '0;
                si_next = '0;
                sj_next = '0;
                sk_next = '0;
                state_next = ST_INF_MUL;
            end
            ST_INF_MUL:
            begin
                if (step_reg == 5'd9)
                    state_next = ST_INF_SUM;
                else
                begin
                    step_next = step_reg + 1'b1;
                    if (sk_reg == 2'd2)
                    begin
                        sk_next = '0;
                        si_next = si_reg + 1'b1;
                    end
                    else
                        sk_next = sk_reg + 1'b1;
                end
            end
            ST_INF_SUM:
            begin
                step_next = '0;
                state_next = ST_INF_WEIGHT;
            end
            ST_INF_WEIGHT:
            begin
                if (step_reg == 5'd3)
                    state_next = ST_INF_WRITE;
                else
                    step_next = step_reg + 1'b1;
            end
            ST_INF_WRITE:
            begin
                state_next = ST_IDLE;
            end
            ST_RD_WAIT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            si_reg <= '0;
            sj_reg <= '0;
            sk_reg <= '0;
            cnt_reg <= '0;
            active_reg <= '0;
            out_valid_reg <= 1'b0;
            dm_valid_reg <= 1'b0;
            prod_en_reg <= 1'b0;
            for (int n = 0; n < 9; n++)
            begin
                rot_reg[n] <= '0;
                brot_reg[n] <= '0;
            end
            for (int n = 0; n < 3; n++)
            begin
                pos_reg[n] <= '0;
                bpos_reg[n] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            si_reg <= si_next;
            sj_reg <= sj_next;
            sk_reg <= sk_next;
            cnt_reg <= cnt_next;
            prod_en_reg <= mul_en;
            if (cfg.valid && cfg.ready)
                active_reg <= cfg.data;
            if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            if (state_reg == ST_PROD && step_reg == 5'd27 && idx_ok)
                dm_valid_reg <= 1'b1;
            if (cmd.valid && cmd.ready && cmd.data.command == CMD_SET_POSE)
            begin
                if (cmd.data.pose_row < 3'd3)
                begin
                    rot_reg[pbase] <= cmd.data.value_a;
                    rot_reg[pbase + 4'd1] <= cmd.data.value_b;
                    rot_reg[pbase + 4'd2] <= cmd.data.value_c;
                    pos_reg[prow] <= cmd.data.position_part;
                    dm_valid_reg <= 1'b0;
                end
                else if (cmd.data.pose_row < 3'd6)
                begin
                    brot_reg[pbase] <= cmd.data.value_a;
                    brot_reg[pbase + 4'd1] <= cmd.data.value_b;
                    brot_reg[pbase + 4'd2] <= cmd.data.value_c;
                    bpos_reg[prow] <= cmd.data.position_part;
                    dm_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
            item_reg <= cmd.data;
        prod_reg <= $signed(mul_a) * $signed(mul_b);
        pi_reg <= si_reg;
        pj_reg <= sj_reg;
        pm_reg <= dm_idx;
        case (state_reg)
            ST_PROD:
            begin
                if (step_reg == 5'd0)
                    acc_reg <= '0;
                else if (prod_en_reg)
                begin
                    // The product of the previous step arrives now.
                    if (pj_reg == 2'd0)
                        acc_reg <= 50'(prod_reg >>> 16);
                    else
                        acc_reg <= acc_reg + 50'(prod_reg >>> 16);
                    if (pj_reg == 2'd2)
                        dm_reg[pm_reg] <= sat32(acc_reg + 50'(prod_reg >>> 16));
                end
            end
            ST_INF_DIFF:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    d_reg[n] <= sat32(50'(src_rd_reg[n]) - 50'(bpos_reg[n]));
                    e_reg[n] <= 50'(pos_reg[n]) - 50'(src_rd_reg[n]);
                end
            end
            ST_INF_MUL:
            begin
                if (step_reg != 5'd0)
                    e_reg[pi_reg] <= e_reg[pi_reg] + 50'(prod_reg >>> 16);
            end
            ST_INF_SUM:
            begin
                for (int n = 0; n < 3; n++)
                    es_reg[n] <= sat47(e_reg[n]);
            end
            ST_INF_WEIGHT:
            begin
                if (step_reg != 5'd3)
                    new_reg[step_reg[1:0]] <= sat32(50'(skn_rd_reg[step_reg[1:0]]) +
                        50'((66'(es_reg[step_reg[1:0]]) * $signed({1'b0, wclamp})) >>> 16));
            end
            ST_OUT:
            begin
                if (idx_ok)
                begin
                    out_reg.out_x <= skn_rd_reg[0];
                    out_reg.out_y <= skn_rd_reg[1];
                    out_reg.out_z <= skn_rd_reg[2];
                end
                else
                    out_reg <= '0;
            end
            default:
            begin
            end
        endcase
    end

    // Vertex memories: one read port, one write port each.
    always_ff @(posedge clk)
    begin
        for (int n = 0; n < 3; n++)
        begin
            src_rd_reg[n] <= src_mem[(state_reg == ST_COPY_READ) ? caddr : vaddr][n];
            skn_rd_reg[n] <= skn_mem[vaddr][n];
        end
        if (state_reg == ST_IDLE && cmd.valid && cmd.ready &&
            cmd.data.command == CMD_LOAD_SOURCE && load_ok)
        begin
            src_mem[AW'(cmd.data.vertex_index)][0] <= cmd.data.value_a;
            src_mem[AW'(cmd.data.vertex_index)][1] <= cmd.data.value_b;
            src_mem[AW'(cmd.data.vertex_index)][2] <= cmd.data.value_c;
        end
        if (state_reg == ST_COPY_WRITE)
            for (int n = 0; n < 3; n++)
                skn_mem[caddr][n] <= src_rd_reg[n];
        else if (state_reg == ST_INF_WRITE)
            for (int n = 0; n < 3; n++)
                skn_mem[vaddr][n] <= new_reg[n];
    end

endmodule
`default_nettype wire

// ===== sv/lbs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// lbs_checker
// Port-level checks of the skinning block, bound to the top level.
// ============================================================================
module lbs_checker
    import lbs_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire vertex_item_t res_data
);
    // A result is shown only while no command is taken.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !cmd_ready)
        else $error("command taken while a result waits");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // A taken command does not become a result in the next cycle.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !res_valid)
        else $error("result too early");
endmodule

bind linear_blend_skinning_top lbs_checker u_lbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);
`default_nettype wire
